@@ src/tst_pkg.sv @@
// Package with the shared types, codes and helper function of the snippet truncator.
`timescale 1ns / 1ps

package tst_pkg;

  // Buffer geometry.
  localparam int BUFFER_BYTES = 1024;
  localparam int BUF_AW       = $clog2(BUFFER_BYTES);
  localparam int LEN_W        = 11;
  localparam int MAXLEN_W     = 10;
  localparam logic [MAXLEN_W-1:0] MAXLEN_RESET = 10'd256;

  // Action codes.
  localparam logic [1:0] ACT_PUSH  = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  // Status codes.
  localparam logic [1:0] ST_APPENDED = 2'd0;
  localparam logic [1:0] ST_BLANK    = 2'd1;
  localparam logic [1:0] ST_TRUNC    = 2'd2;
  localparam logic [1:0] ST_IGNORED  = 2'd3;

  // Byte constants.
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [20:0] CP_SPACE = 21'h20;
  localparam logic [20:0] CP_NBSP  = 21'hA0;

  typedef struct packed {
    logic [1:0]  action;
    logic [20:0] code_point;
    logic [9:0]  read_index;
  } tst_in_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [LEN_W-1:0] length;
    logic [7:0]       read_byte;
    logic             finished;
  } tst_out_t;

  // Byte sequence, first byte in the top bits, with its byte count.
  typedef struct packed {
    logic [31:0] seq;
    logic [2:0]  cnt;
  } tst_seq_t;

  // UTF-8 encoding of a code point from its low 21 bits.
  function automatic tst_seq_t utf8_encode(input logic [20:0] cp);
    tst_seq_t r;
    if (cp < 21'h80) begin
      r.seq = {1'b0, cp[6:0], 24'h0};
      r.cnt = 3'd1;
    end else if (cp < 21'h800) begin
      r.seq = {3'b110, cp[10:6], 2'b10, cp[5:0], 16'h0};
      r.cnt = 3'd2;
    end else if (cp < 21'h10000) begin
      r.seq = {4'b1110, cp[15:12], 2'b10, cp[11:6], 2'b10, cp[5:0], 8'h0};
      r.cnt = 3'd3;
    end else begin
      r.seq = {5'b11110, cp[20:18], 2'b10, cp[17:12], 2'b10, cp[11:6], 2'b10, cp[5:0]};
      r.cnt = 3'd4;
    end
    return r;
  endfunction

endpackage

@@ src/tst_ram.sv @@
// Generic simple dual-port RAM with a registered read.
`timescale 1ns / 1ps

module tst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/text_snippet_truncator_core.sv @@
// Top level of the snippet truncator: sequencer, state registers and buffer memory.
`timescale 1ns / 1ps

// The block takes one command when start is high and busy is low, and answers every
// command with exactly one result, shown for one cycle with out_valid; the receiver
// cannot stall it. Bytes go into the buffer memory one per cycle through its single
// write port, so a push that stores n bytes (1 to 4 for a character, 3 or 4 for the
// cut tail) keeps busy high while they are written, and its result follows in the
// next cycle. A read holds busy while the memory read completes. A clear, a blank
// that is dropped, a push after the cut and the unused action do not raise busy, and
// their result comes in the cycle after the transfer. max_length may be written
// through the cfg channel whenever busy is low.
module text_snippet_truncator_core
  import tst_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  tst_in_t             in_data,
  output logic                out_valid,
  output tst_out_t            out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [MAXLEN_W-1:0] cfg_data
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_WRITE = 2'd1;
  localparam logic [1:0] S_READ  = 2'd2;

  localparam logic [LEN_W-1:0] BUF_LIMIT = LEN_W'(BUFFER_BYTES);

  logic [1:0]          state_r, state_nxt;
  logic [LEN_W-1:0]    len_r, len_nxt;
  logic [LEN_W-1:0]    wend_r, wend_nxt;
  logic                blank_r, blank_nxt;
  logic                trunc_r, trunc_nxt;
  logic [MAXLEN_W-1:0] maxlen_r;
  logic [31:0]         seq_r, seq_nxt;
  logic [2:0]          cnt_r, cnt_nxt;
  logic [1:0]          stat_r, stat_nxt;
  logic                rd_ok_r, rd_ok_nxt;
  logic                out_valid_r, out_valid_nxt;
  tst_out_t            out_data_r, out_data_nxt;

  logic                accept;
  logic                is_blank;
  tst_seq_t            enc;
  logic                use_word;
  logic [LEN_W-1:0]    cut_pos;
  logic                ram_we;
  logic [7:0]          ram_rdata;
  logic                room;

  assign accept    = start && !busy;
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = !busy;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Character class, encoding and cut position of the pending command.
  assign is_blank = (in_data.code_point <= CP_SPACE) || (in_data.code_point == CP_NBSP);
  assign enc      = utf8_encode(in_data.code_point);
  assign use_word = wend_r > LEN_W'(maxlen_r >> 1);
  assign cut_pos  = (maxlen_r >= MAXLEN_W'(3)) ? LEN_W'(maxlen_r - MAXLEN_W'(3)) : '0;
  assign room     = len_r < BUF_LIMIT;

  // Buffer memory: written during byte transfers, read at the requested index.
  assign ram_we = (state_r == S_WRITE) && room;

  tst_ram #(
    .WIDTH(8),
    .DEPTH(BUFFER_BYTES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (len_r[BUF_AW-1:0]),
    .wdata (seq_r[31:24]),
    .raddr (in_data.read_index[BUF_AW-1:0]),
    .rdata (ram_rdata)
  );

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    len_nxt       = len_r;
    wend_nxt      = wend_r;
    blank_nxt     = blank_r;
    trunc_nxt     = trunc_r;
    seq_nxt       = seq_r;
    cnt_nxt       = cnt_r;
    stat_nxt      = stat_r;
    rd_ok_nxt     = rd_ok_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_data.action)
            ACT_PUSH: begin
              if (trunc_r) begin
                out_valid_nxt = 1'b1;
                out_data_nxt  = '{ST_IGNORED, len_r, 8'h00, 1'b1};
              end else if (len_r >= LEN_W'(maxlen_r)) begin
                // Cut at the last word end or at max_length-3, then add the tail.
                trunc_nxt = 1'b1;
                stat_nxt  = ST_TRUNC;
                state_nxt = S_WRITE;
                if (use_word) begin
                  len_nxt = wend_r;
                  seq_nxt = {CH_SPACE, CH_DOT, CH_DOT, CH_DOT};
                  cnt_nxt = 3'd4;
                end else begin
                  len_nxt = cut_pos;
                  seq_nxt = {CH_DOT, CH_DOT, CH_DOT, 8'h00};
                  cnt_nxt = 3'd3;
                end
              end else if (is_blank) begin
                if (!blank_r) begin
                  blank_nxt = 1'b1;
                  wend_nxt  = len_r;
                  seq_nxt   = {CH_SPACE, 24'h0};
                  cnt_nxt   = 3'd1;
                  stat_nxt  = ST_BLANK;
                  state_nxt = S_WRITE;
                end else begin
                  out_valid_nxt = 1'b1;
                  out_data_nxt  = '{ST_BLANK, len_r, 8'h00, 1'b0};
                end
              end else begin
                blank_nxt = 1'b0;
                seq_nxt   = enc.seq;
                cnt_nxt   = enc.cnt;
                stat_nxt  = ST_APPENDED;
                state_nxt = S_WRITE;
              end
            end
            ACT_READ: begin
              rd_ok_nxt = {1'b0, in_data.read_index} < len_r;
              state_nxt = S_READ;
            end
            ACT_CLEAR: begin
              len_nxt       = '0;
              wend_nxt      = '0;
              blank_nxt     = 1'b1;
              trunc_nxt     = 1'b0;
              out_valid_nxt = 1'b1;
              out_data_nxt  = '{ST_APPENDED, '0, 8'h00, 1'b0};
            end
            default: begin
              out_valid_nxt = 1'b1;
              out_data_nxt  = '{ST_IGNORED, len_r, 8'h00, trunc_r};
            end
          endcase
        end
      end
      S_WRITE: begin
        // One byte per cycle; the length saturates at the buffer size.
        if (room) begin
          len_nxt = len_r + LEN_W'(1);
        end
        seq_nxt = {seq_r[23:0], 8'h00};
        cnt_nxt = cnt_r - 3'd1;
        if (cnt_r == 3'd1) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{stat_r, len_nxt, 8'h00, trunc_r};
        end
      end
      S_READ: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
        out_data_nxt  = '{ST_APPENDED, len_r, (rd_ok_r ? ram_rdata : 8'h00), trunc_r};
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len_r       <= '0;
      wend_r      <= '0;
      blank_r     <= 1'b1;
      trunc_r     <= 1'b0;
      maxlen_r    <= MAXLEN_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      wend_r      <= wend_nxt;
      blank_r     <= blank_nxt;
      trunc_r     <= trunc_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        maxlen_r <= cfg_data;
      end
    end
  end

  // Working and result payload.
  always_ff @(posedge clk) begin
    seq_r      <= seq_nxt;
    cnt_r      <= cnt_nxt;
    stat_r     <= stat_nxt;
    rd_ok_r    <= rd_ok_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

@@ src/tst_chk.sv @@
// Port-level checker for the snippet truncator and its bind statement.
`timescale 1ns / 1ps

module tst_chk
  import tst_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     start,
  input logic     busy,
  input logic     out_valid,
  input tst_out_t out_data
);

  // A result never overlaps a busy cycle.
  a_result_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  // A result follows a transfer or the end of a busy stretch.
  a_result_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(start) && !$past(busy)) || $past(busy))
    else $error("result without a command");

  // The length never exceeds the buffer size.
  a_length_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.length <= LEN_W'(BUFFER_BYTES))
    else $error("length beyond buffer");

  // A cut always reports the finished flag.
  a_trunc_finished: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == ST_TRUNC) |-> out_data.finished)
    else $error("truncation without finished");

  // A blank is only handled on an unfinished snippet.
  a_blank_open: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == ST_BLANK) |-> !out_data.finished)
    else $error("blank handled after finish");

endmodule

bind text_snippet_truncator_core tst_chk u_tst_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);

@@ sim/testbench.sv @@
// Self-checking testbench of the snippet truncator: stimulus, reference prediction and checks.
`timescale 1ns / 1ps

module testbench;
  import tst_pkg::*;

  // The fourth action code has no name in the package; the block reports it as ignored.
  localparam logic [1:0] ACT_NOP = 2'd3;
  localparam int STALL_LIMIT = 1000;
  localparam int IDLE_PCT    = 23;

  logic                clk;
  logic                rst_n     = 1'b0;
  logic                start     = 1'b0;
  logic                busy;
  tst_in_t             in_data   = '0;
  logic                out_valid;
  tst_out_t            out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [MAXLEN_W-1:0] cfg_data  = '0;

  text_snippet_truncator_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // Tracks the snippet the block should hold and the results it owes, in command order.
  class snippet_scoreboard;
    logic [7:0] text_mem [BUFFER_BYTES];
    int         text_len;
    int         word_end_at;
    int         cut_at_len;
    bit         in_blanks;
    bit         done;
    tst_out_t   expected_q [$];
    int         errors;
    int         commands;
    int         results;
    int         settings;
    int         cuts;

    function new();
      text_len    = 0;
      word_end_at = 0;
      in_blanks   = 1'b1;
      done        = 1'b0;
      cut_at_len  = int'(MAXLEN_RESET);
    endfunction

    function void set_max_length(int value);
      cut_at_len = value & 32'h3FF;
      settings++;
    endfunction

    // Bytes past the end of the buffer are dropped and the length saturates.
    function void store_byte(logic [7:0] value);
      if (text_len < BUFFER_BYTES) begin
        text_mem[text_len[BUF_AW-1:0]] = value;
        text_len++;
      end
    endfunction

    // UTF-8 from the low 21 bits, so out-of-range values take the four-byte form.
    function void store_char(logic [20:0] cp);
      if (cp < 21'h80) begin
        store_byte({1'b0, cp[6:0]});
      end else if (cp < 21'h800) begin
        store_byte({3'b110, cp[10:6]});
        store_byte({2'b10, cp[5:0]});
      end else if (cp < 21'h10000) begin
        store_byte({4'b1110, cp[15:12]});
        store_byte({2'b10, cp[11:6]});
        store_byte({2'b10, cp[5:0]});
      end else begin
        store_byte({5'b11110, cp[20:18]});
        store_byte({2'b10, cp[17:12]});
        store_byte({2'b10, cp[11:6]});
        store_byte({2'b10, cp[5:0]});
      end
    endfunction

    // Cut at the last word end when it lies past half the limit, else hard at limit - 3.
    function void cut_snippet();
      int cut_pos;
      if (word_end_at > cut_at_len / 2) begin
        text_len = word_end_at;
        store_byte(CH_SPACE);
      end else begin
        cut_pos  = (cut_at_len >= 3) ? cut_at_len - 3 : 0;
        text_len = cut_pos;
      end
      repeat (3) store_byte(CH_DOT);
      done = 1'b1;
      cuts++;
    endfunction

    // Applies one accepted command and queues the result it must produce.
    function void note_command(tst_in_t c);
      tst_out_t e;
      e = '0;
      case (c.action)
        ACT_PUSH: begin
          if (done) begin
            e.status = ST_IGNORED;
          end else if (text_len >= cut_at_len) begin
            cut_snippet();
            e.status = ST_TRUNC;
          end else if (c.code_point <= CP_SPACE || c.code_point == CP_NBSP) begin
            if (!in_blanks) begin
              in_blanks   = 1'b1;
              word_end_at = text_len;
              store_byte(CH_SPACE);
            end
            e.status = ST_BLANK;
          end else begin
            store_char(c.code_point);
            in_blanks = 1'b0;
            e.status  = ST_APPENDED;
          end
        end
        ACT_READ: begin
          if (c.read_index < text_len) e.read_byte = text_mem[c.read_index];
        end
        ACT_CLEAR: begin
          text_len    = 0;
          word_end_at = 0;
          in_blanks   = 1'b1;
          done        = 1'b0;
        end
        default: begin
          e.status = ST_IGNORED;
        end
      endcase
      e.length   = LEN_W'(text_len);
      e.finished = done;
      expected_q.push_back(e);
      commands++;
    endfunction

    function void compare_field(string name, logic [15:0] exp_v, logic [15:0] got_v);
      if (got_v !== exp_v) begin
        $error("%s: expected %0d, got %0d", name, exp_v, got_v);
        errors++;
      end
    endfunction

    function void check_result(tst_out_t got);
      tst_out_t e;
      results++;
      if (expected_q.size() == 0) begin
        $error("result with no command waiting: status %0d length %0d",
               got.status, got.length);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      compare_field("status", 16'(e.status), 16'(got.status));
      compare_field("length", 16'(e.length), 16'(got.length));
      compare_field("read_byte", 16'(e.read_byte), 16'(got.read_byte));
      compare_field("finished", 16'(e.finished), 16'(got.finished));
    endfunction
  endclass

  snippet_scoreboard sb;
  bit idle_on = 1'b1;
  int stall_cycles = 0;
  int seen_activity = 0;

  // Clock with a 2 ns period.
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Every strobed result is a transfer; the block cannot be held off.
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1) sb.check_result(out_data);
  end

  // Ends the run when no transfer of any kind happens for too long.
  always @(posedge clk) begin
    if (sb.commands + sb.results + sb.settings != seen_activity) begin
      seen_activity = sb.commands + sb.results + sb.settings;
      stall_cycles  = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  function automatic tst_in_t make_command(logic [1:0] act, logic [20:0] cp, logic [9:0] idx);
    tst_in_t c;
    c.action     = act;
    c.code_point = cp;
    c.read_index = idx;
    return c;
  endfunction

  // Blanks about one push in six; long snippets lean toward multi-byte characters.
  function automatic logic [20:0] pick_code_point(bit big);
    int k;
    k = $urandom_range(0, 99);
    if (k < 3) return CP_NBSP;
    if (k < 18) return 21'($urandom_range(0, 32));
    k = $urandom_range(0, 99);
    if (k < (big ? 30 : 55)) return 21'($urandom_range(21'h21, 21'h7F));
    if (k < (big ? 45 : 70)) return 21'($urandom_range(21'h80, 21'h7FF));
    if (k < (big ? 70 : 85)) return 21'($urandom_range(21'h800, 21'hFFFF));
    return 21'($urandom_range(21'h10000, 21'h1FFFFF));
  endfunction

  // Mostly pushes forming words, with reads, clears, and a little noise.
  function automatic tst_in_t rand_command(bit big);
    tst_in_t c;
    int      r;
    c = make_command(ACT_PUSH, 21'($urandom_range(0, 21'h1FFFFF)),
                     10'($urandom_range(0, 1023)));
    r = $urandom_range(0, 99);
    if (r < (big ? 0 : 3) || (sb.done && r < 30)) begin
      c.action = ACT_CLEAR;
    end else if (r == 99) begin
      c.action = ACT_NOP;
    end else if (r >= 84) begin
      c.action = ACT_READ;
      if (sb.text_len > 0 && r < 95) c.read_index = 10'($urandom_range(0, sb.text_len - 1));
    end else begin
      c.code_point = pick_code_point(big);
    end
    return c;
  endfunction

  // Offers one command and waits for its transfer; start stays high afterwards.
  task automatic send_command(tst_in_t c);
    int gap;
    gap = 0;
    if (idle_on && $urandom_range(0, 99) < IDLE_PCT) gap = $urandom_range(1, 3);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= c;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_command(c);
  endtask

  // Writes max_length once the block has drained every result it owes.
  task automatic write_max_length(int value);
    start <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= MAXLEN_W'(value);
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    sb.set_max_length(value);
  endtask

  initial begin
    tst_in_t directed [$];
    int      limits [$];
    int      budget;
    bit      big;
    sb = new();

    // Synchronous reset held low, then released.
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Leading blanks, encoding boundaries, out-of-range values, reads and the unused action.
    directed = '{
      make_command(ACT_PUSH, CP_SPACE, 10'd0),
      make_command(ACT_PUSH, 21'h0, 10'd0),
      make_command(ACT_PUSH, CP_NBSP, 10'd0),
      make_command(ACT_PUSH, 21'h41, 10'd0),
      make_command(ACT_PUSH, 21'h7F, 10'd0),
      make_command(ACT_PUSH, 21'h80, 10'd0),
      make_command(ACT_PUSH, 21'h7FF, 10'd0),
      make_command(ACT_PUSH, 21'h800, 10'd0),
      make_command(ACT_PUSH, 21'hFFFF, 10'd0),
      make_command(ACT_PUSH, 21'h10000, 10'd0),
      make_command(ACT_PUSH, 21'h10FFFF, 10'd0),
      make_command(ACT_PUSH, 21'h1FFFFF, 10'd0),
      make_command(ACT_PUSH, 21'hD800, 10'd0),
      make_command(ACT_PUSH, CP_SPACE, 10'd0),
      make_command(ACT_PUSH, CP_NBSP, 10'd0),
      make_command(ACT_PUSH, 21'h21, 10'd0),
      make_command(ACT_READ, 21'h0, 10'd0),
      make_command(ACT_READ, 21'h1FFFFF, 10'd1),
      make_command(ACT_READ, 21'h0, 10'd28),
      make_command(ACT_READ, 21'h0, 10'd29),
      make_command(ACT_READ, 21'h0, 10'd1023),
      make_command(ACT_NOP, 21'h1FFFFF, 10'd1023),
      make_command(ACT_CLEAR, 21'h0, 10'd0),
      make_command(ACT_READ, 21'h0, 10'd0),
      make_command(ACT_PUSH, 21'h10, 10'd0)
    };
    foreach (directed[i]) send_command(directed[i]);

    // Limit settings: the extremes, tiny values that force an early cut, and random ones.
    limits = '{6, 1020, 0, 1, 2, 3, 1023, 7, 512, int'($urandom_range(6, 1020)),
               int'($urandom_range(6, 1020)), int'($urandom_range(6, 60)), 256};
    foreach (limits[p]) begin
      write_max_length(limits[p]);
      big    = limits[p] >= 512;
      budget = big ? 250 : 34;
      // One stretch of the run goes without any idle cycles.
      idle_on = (p != 1);
      if (limits[p] == 1023) begin
        // Fill with four-byte characters so that a four-byte push runs past the buffer end.
        send_command(make_command(ACT_CLEAR, 21'h0, 10'd0));
        repeat (255) send_command(make_command(ACT_PUSH,
                                  21'($urandom_range(21'h10000, 21'h1FFFFF)), 10'd0));
        repeat (2) send_command(make_command(ACT_PUSH,
                                21'($urandom_range(21'h21, 21'h7E)), 10'd0));
        send_command(make_command(ACT_PUSH, 21'($urandom_range(21'h10000, 21'h1FFFFF)),
                                  10'd0));
        send_command(make_command(ACT_PUSH, 21'h41, 10'd0));
        send_command(make_command(ACT_READ, 21'h0, 10'd1023));
        send_command(make_command(ACT_READ, 21'h0, 10'd1022));
        send_command(make_command(ACT_READ, 21'h0, 10'd1019));
        send_command(make_command(ACT_PUSH, 21'h41, 10'd0));
        send_command(make_command(ACT_CLEAR, 21'h0, 10'd0));
      end
      repeat (budget) send_command(rand_command(big));
    end

    // Drain, then leave room for any stray result.
    start <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Ran %0d commands and checked %0d results across %0d max_length settings.",
             sb.commands, sb.results, sb.settings + 1);
    $display("Snippets were cut %0d times, including a fill past the buffer end.", sb.cuts);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
